@@ src/fsp_pkg.sv @@
// ----------------------------------------------------------------------------
// fsp_pkg
// Shared types and constants of the servo position control pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package fsp_pkg;

  // samples per averaging window
  localparam int AvgCount = 5;
  localparam logic [3:0] AvgCountV = 4'(AvgCount);

  // reciprocal of the window length, rounded up, exact for 16-bit sums
  localparam int AvgShift = 16 + $clog2(AvgCount);
  localparam int AvgProdW = AvgShift + 16;
  localparam logic [16:0] AvgRecip =
    17'(((64'd1 << AvgShift) + 64'(AvgCount) - 64'd1) / 64'(AvgCount));

  // 0.342 in Q0.16, pulse average to degrees
  localparam logic [14:0] PosScale = 15'd22413;

  // reciprocal of ten, exact for 16-bit products
  localparam logic [15:0] Div10Recip = 16'd52429;
  localparam int Div10Shift = 19;

  // angle and speed constants
  localparam logic [10:0] FullTurn  = 11'd360;
  localparam logic [8:0]  HalfTurn  = 9'd180;
  localparam logic [10:0] WrapBias  = 11'd1260;  // half turn plus three full turns
  localparam logic [7:0]  ServoCenter = 8'd90;
  localparam logic [6:0]  SpeedLimit  = 7'd90;

  // configuration register indexes
  typedef enum logic [2:0] {
    CfgStopDistance = 3'd0,
    CfgSlowDistance = 3'd1,
    CfgSlowSpeed    = 3'd2,
    CfgMaxSpeed     = 3'd3,
    CfgGainTenths   = 3'd4,
    CfgPulseOffset  = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] stop_distance;
    logic [7:0] slow_distance;
    logic [6:0] slow_speed;
    logic [6:0] max_speed;
    logic [7:0] gain_tenths;
    logic [7:0] pulse_offset;
  } cfg_t;

  // accumulator stage to position stage
  typedef struct packed {
    logic [15:0] sum;
    logic        upd;
    logic [8:0]  target;
  } acc_item_t;

  // position stage to speed stage
  typedef struct packed {
    logic [9:0] pos;
    logic       upd;
    logic [8:0] target;
  } pos_item_t;

  // one result, servo_command in the lowest bits
  typedef struct packed {
    logic              at_target;
    logic              upd;
    logic [9:0]        pos;
    logic signed [7:0] sspeed;
    logic [7:0]        servo;
  } res_t;

endpackage

`default_nettype wire

@@ src/fsp_cfg.sv @@
// ----------------------------------------------------------------------------
// fsp_cfg
// Control register file, written through an index and data request channel.
// ----------------------------------------------------------------------------
`default_nettype none

module fsp_cfg import fsp_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       wr_valid_i,
  output logic            wr_ready_o,
  input  wire logic [2:0] wr_index_i,
  input  wire logic [7:0] wr_data_i,
  output cfg_t            cfg_o
);

  cfg_t cfg_q;

  assign wr_ready_o = 1'b1;
  assign cfg_o      = cfg_q;

  // register writes, unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.stop_distance <= 8'd3;
      cfg_q.slow_distance <= 8'd8;
      cfg_q.slow_speed    <= 7'd30;
      cfg_q.max_speed     <= 7'd90;
      cfg_q.gain_tenths   <= 8'd27;
      cfg_q.pulse_offset  <= 8'd30;
    end else if (wr_valid_i) begin
      unique case (cfg_idx_e'(wr_index_i))
        CfgStopDistance: cfg_q.stop_distance <= wr_data_i;
        CfgSlowDistance: cfg_q.slow_distance <= wr_data_i;
        CfgSlowSpeed:    cfg_q.slow_speed    <= wr_data_i[6:0];
        CfgMaxSpeed:     cfg_q.max_speed     <= wr_data_i[6:0];
        CfgGainTenths:   cfg_q.gain_tenths   <= wr_data_i;
        CfgPulseOffset:  cfg_q.pulse_offset  <= wr_data_i;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ src/fsp_accum.sv @@
// ----------------------------------------------------------------------------
// fsp_accum
// Input register stage: offset removal, pulse accumulation, window counting.
// ----------------------------------------------------------------------------
`default_nettype none

module fsp_accum import fsp_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [7:0]  pulse_offset_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [10:0] pulse_width_i,
  input  wire logic [8:0]  target_angle_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output acc_item_t        out_item_o
);

  logic [15:0] acc_q, acc_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [10:0] contrib;
  logic [15:0] acc_sum;
  logic [3:0]  cnt_inc;
  logic        win;
  logic        accept;
  logic        valid_q;
  acc_item_t   item_q, item_d;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

  // offset removal floored at zero, then accumulate
  always_comb begin
    contrib = (pulse_width_i > {3'b000, pulse_offset_i}) ?
              (pulse_width_i - {3'b000, pulse_offset_i}) : '0;
    acc_sum = acc_q + {5'b00000, contrib};
    cnt_inc = cnt_q + 4'd1;
    win     = (cnt_inc >= AvgCountV);
    acc_d   = acc_q;
    cnt_d   = cnt_q;
    if (accept) begin
      acc_d = win ? '0 : acc_sum;
      cnt_d = win ? '0 : cnt_inc;
    end
    item_d.sum    = acc_sum;
    item_d.upd    = win;
    item_d.target = target_angle_i;
  end

  // accumulator state and stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      cnt_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      acc_q <= acc_d;
      cnt_q <= cnt_d;
      if (in_ready_o) begin
        valid_q <= in_valid_i;
      end
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q < AvgCountV)
    else $error("sample count reached window length");
  a_win_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && win) |=> (acc_q == '0 && cnt_q == '0))
    else $error("accumulator not cleared after window");
`endif

endmodule

`default_nettype wire

@@ src/fsp_position.sv @@
// ----------------------------------------------------------------------------
// fsp_position
// Two stages: window average by reciprocal multiply, then scaling to degrees
// and the held position estimate.
// ----------------------------------------------------------------------------
`default_nettype none

module fsp_position import fsp_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire acc_item_t in_item_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output pos_item_t      out_item_o
);

  logic [AvgProdW-1:0] avg_prod;
  logic [15:0]         avg_d, avg_q;
  logic                upd_a_q;
  logic [8:0]          tgt_a_q;
  logic                va_q, vb_q;
  logic                rdy_a, rdy_b;
  logic [30:0]         pos_prod;
  logic [9:0]          pos_sel;
  logic [9:0]          pos_q;
  pos_item_t           item_q;

  assign rdy_b       = !vb_q || out_ready_i;
  assign rdy_a       = !va_q || rdy_b;
  assign in_ready_o  = rdy_a;
  assign out_valid_o = vb_q;
  assign out_item_o  = item_q;

  // sum divided by the window length
  always_comb begin
    avg_prod = AvgProdW'(in_item_i.sum) * AvgProdW'(AvgRecip);
    avg_d    = avg_prod[AvgProdW-1:AvgShift];
  end

  // average scaled to degrees, old estimate kept outside a window end
  always_comb begin
    pos_prod = 31'(avg_q) * 31'(PosScale);
    pos_sel  = upd_a_q ? pos_prod[25:16] : pos_q;
  end

  // stage valids and position estimate
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q  <= 1'b0;
      vb_q  <= 1'b0;
      pos_q <= '0;
    end else begin
      if (rdy_a) begin
        va_q <= in_valid_i;
      end
      if (rdy_b) begin
        vb_q <= va_q;
      end
      if (rdy_b && va_q) begin
        pos_q <= pos_sel;
      end
    end
  end

  // stage payloads
  always_ff @(posedge clk_i) begin
    if (rdy_a) begin
      avg_q   <= avg_d;
      upd_a_q <= in_item_i.upd;
      tgt_a_q <= in_item_i.target;
    end
    if (rdy_b) begin
      item_q.pos    <= pos_sel;
      item_q.upd    <= upd_a_q;
      item_q.target <= tgt_a_q;
    end
  end

`ifndef SYNTHESIS
  a_pos_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rdy_b && va_q && !upd_a_q) |=> $stable(pos_q))
    else $error("position estimate moved outside a window end");
`endif

endmodule

`default_nettype wire

@@ src/fsp_speed.sv @@
// ----------------------------------------------------------------------------
// fsp_speed
// Four stages: wrapped angular error, gain product, divide by ten, speed
// selection into the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module fsp_speed import fsp_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire cfg_t      cfg_i,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire pos_item_t in_item_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output res_t           out_res_o
);

  logic [3:0]  v_q;
  logic [3:0]  rdy;

  // error stage
  logic [10:0] u;
  logic [10:0] m;
  logic        neg_d;
  logic [7:0]  mag_d;
  logic [7:0]  mag_e_q;
  logic        neg_e_q, upd_e_q;
  logic [9:0]  pos_e_q;

  // gain product stage
  logic [15:0] prod_q;
  logic [7:0]  mag_p_q;
  logic        neg_p_q, upd_p_q;
  logic [9:0]  pos_p_q;

  // quotient stage
  logic [31:0] quot_full;
  logic [12:0] quot_q;
  logic [7:0]  mag_q_q;
  logic        neg_q_q, upd_q_q;
  logic [9:0]  pos_q_q;

  // selection
  logic [12:0] prop;
  logic [6:0]  speed_raw;
  logic [6:0]  speed;
  logic [7:0]  sspeed;
  res_t        res_d, res_q;

  assign rdy[3]      = !v_q[3] || out_ready_i;
  assign rdy[2]      = !v_q[2] || rdy[3];
  assign rdy[1]      = !v_q[1] || rdy[2];
  assign rdy[0]      = !v_q[0] || rdy[1];
  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[3];
  assign out_res_o   = res_q;

  // wrapped error, target minus position into -180..179
  always_comb begin
    u = 11'(in_item_i.target) + WrapBias - 11'(in_item_i.pos);
    if (u >= 11'(4 * 360)) begin
      m = u - 11'(4 * 360);
    end else if (u >= 11'(3 * 360)) begin
      m = u - 11'(3 * 360);
    end else if (u >= 11'(2 * 360)) begin
      m = u - 11'(2 * 360);
    end else if (u >= FullTurn) begin
      m = u - FullTurn;
    end else begin
      m = u;
    end
    neg_d = (m[8:0] < HalfTurn);
    mag_d = neg_d ? 8'(HalfTurn - m[8:0]) : 8'(m[8:0] - HalfTurn);
  end

  // proportional quotient by ten
  always_comb begin
    quot_full = 32'(prod_q) * 32'(Div10Recip);
  end

  // speed band selection and command
  always_comb begin
    prop = (quot_q < 13'(cfg_i.slow_speed)) ? 13'(cfg_i.slow_speed) : quot_q;
    if (prop > 13'(cfg_i.max_speed)) begin
      prop = 13'(cfg_i.max_speed);
    end
    if (mag_q_q < cfg_i.stop_distance) begin
      speed_raw = '0;
    end else if (mag_q_q < cfg_i.slow_distance) begin
      speed_raw = cfg_i.slow_speed;
    end else begin
      speed_raw = prop[6:0];
    end
    speed = (speed_raw > SpeedLimit) ? SpeedLimit : speed_raw;
    sspeed = neg_q_q ? {1'b0, speed} : (8'd0 - {1'b0, speed});
    res_d.servo     = ServoCenter + sspeed;
    res_d.sspeed    = sspeed;
    res_d.pos       = pos_q_q;
    res_d.upd       = upd_q_q;
    res_d.at_target = (speed == '0);
  end

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= in_valid_i;
      if (rdy[1]) v_q[1] <= v_q[0];
      if (rdy[2]) v_q[2] <= v_q[1];
      if (rdy[3]) v_q[3] <= v_q[2];
    end
  end

  // stage payloads
  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      mag_e_q <= mag_d;
      neg_e_q <= neg_d;
      upd_e_q <= in_item_i.upd;
      pos_e_q <= in_item_i.pos;
    end
    if (rdy[1]) begin
      prod_q  <= 16'(mag_e_q) * 16'(cfg_i.gain_tenths);
      mag_p_q <= mag_e_q;
      neg_p_q <= neg_e_q;
      upd_p_q <= upd_e_q;
      pos_p_q <= pos_e_q;
    end
    if (rdy[2]) begin
      quot_q  <= quot_full[31:Div10Shift];
      mag_q_q <= mag_p_q;
      neg_q_q <= neg_p_q;
      upd_q_q <= upd_p_q;
      pos_q_q <= pos_p_q;
    end
    if (rdy[3]) begin
      res_q <= res_d;
    end
  end

`ifndef SYNTHESIS
  a_stop_center: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[3] && res_q.at_target) |-> (res_q.servo == ServoCenter && res_q.sspeed == 8'sd0))
    else $error("stopped servo not commanded to center");
  a_speed_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[3] |-> (res_q.sspeed >= -8'sd90 && res_q.sspeed <= 8'sd90))
    else $error("commanded speed beyond limit");
`endif

endmodule

`default_nettype wire

@@ src/feedback_servo_position_control_unit.sv @@
// ----------------------------------------------------------------------------
// feedback_servo_position_control_unit
// Proportional position control of one continuous-rotation servo.
// ----------------------------------------------------------------------------
// Each request on s_axis carries one measured feedback pulse width and a
// target angle; each request yields exactly one result on m_axis with the
// servo command, signed speed, position estimate and two flags.
// The config channel writes one register per request (index, data) and is
// always ready; write it only while no request is in flight.
// m_axis_tvalid rises once an accepted request has passed the chain of seven
// register stages (input and accumulator, window average, degree scaling,
// angular error, gain product, divide by ten, speed selection).
// Throughput: one request per cycle while m_axis_tready is high, set by the
// single accumulator update.
// Reset clears the accumulator, sample count and position estimate, loads the
// register defaults and empties the pipeline.
// When the receiver stalls, each stage holds its request and the pipeline
// fills; s_axis_tready falls once all seven stages are occupied.
// ----------------------------------------------------------------------------
`default_nettype none

module feedback_servo_position_control_unit import fsp_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration write channel
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [7:0]  cfg_data_i,
  // request stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,   // pulse_width[10:0], target_angle[19:11], zero
  // result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata    // servo_command[7:0], signed_speed[15:8],
                                           // position_angle[25:16], position_updated[26],
                                           // at_target[27], zero
);

  cfg_t      cfg;
  logic      acc_valid, acc_ready;
  acc_item_t acc_item;
  logic      pos_valid, pos_ready;
  pos_item_t pos_item;
  res_t      res;

  // register file
  fsp_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (cfg_valid_i),
    .wr_ready_o (cfg_ready_o),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  // accumulation
  fsp_accum u_accum (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .pulse_offset_i (cfg.pulse_offset),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .pulse_width_i  (s_axis_tdata[10:0]),
    .target_angle_i (s_axis_tdata[19:11]),
    .out_valid_o    (acc_valid),
    .out_ready_i    (acc_ready),
    .out_item_o     (acc_item)
  );

  // position estimate
  fsp_position u_position (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (acc_valid),
    .in_ready_o  (acc_ready),
    .in_item_i   (acc_item),
    .out_valid_o (pos_valid),
    .out_ready_i (pos_ready),
    .out_item_o  (pos_item)
  );

  // error and speed command
  fsp_speed u_speed (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (pos_valid),
    .in_ready_o  (pos_ready),
    .in_item_i   (pos_item),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (res)
  );

  assign m_axis_tdata = {4'b0000, res};

endmodule

`default_nettype wire

@@ bench/tb_feedback_servo_position_control_unit.sv @@
// ----------------------------------------------------------------------------
// tb_feedback_servo_position_control_unit
// Self-checking bench for the servo position control pipeline.
// ----------------------------------------------------------------------------
// A short directed plan covers pulse and angle extremes, the stop, slow and
// proportional bands, clamping and ignored register writes. Phases of random
// requests with new register settings follow. Every accepted request is run
// through a local model of the controller, and each result is compared field
// by field against the oldest pending command. Both stream sides idle at
// random, and the receiver holds off once long enough to back up the pipeline.
// ----------------------------------------------------------------------------

module tb_feedback_servo_position_control_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import fsp_pkg::*;

  // spare register indexes, writes to them are dropped
  localparam logic [2:0] CfgSpare6 = 3'd6;
  localparam logic [2:0] CfgSpare7 = 3'd7;
  localparam int NumPhases = 8;
  localparam int PhaseItems = 210;

  typedef enum logic {RowItem, RowReg} row_kind_e;

  typedef struct {
    row_kind_e   kind;
    logic [2:0]  idx;
    logic [7:0]  data;
    logic [10:0] pw;
    logic [8:0]  tgt;
    bit          typed;
    res_t        want;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [7:0]  cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;

  // local model state and register copies
  logic [15:0] acc_sum;
  logic [3:0]  win_cnt;
  logic [9:0]  pos_deg;
  logic [7:0]  cfg_stop;
  logic [7:0]  cfg_slow_dist;
  logic [6:0]  cfg_slow_spd;
  logic [6:0]  cfg_max_spd;
  logic [7:0]  cfg_gain;
  logic [7:0]  cfg_offset;

  res_t  expected_cmds[$];
  row_t  plan_q[$];
  res_t  got_cmd;
  res_t  want_cmd;
  int    mismatch_cnt = 0;
  int    results_seen = 0;
  int    stall_left = 0;
  int    hold_left = 0;
  bit    hold_done = 1'b0;
  bit    steady = 1'b0;
  bit    cfg_open = 1'b0;

  feedback_servo_position_control_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  // run limit
  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // model reset: register defaults and cleared averaging state
  function automatic void servo_model_reset();
    acc_sum = '0;
    win_cnt = '0;
    pos_deg = '0;
    cfg_stop = 8'd3;
    cfg_slow_dist = 8'd8;
    cfg_slow_spd = 7'd30;
    cfg_max_spd = 7'd90;
    cfg_gain = 8'd27;
    cfg_offset = 8'd30;
  endfunction

  function automatic void servo_model_reg(logic [2:0] idx, logic [7:0] data);
    case (idx)
      CfgStopDistance: cfg_stop = data;
      CfgSlowDistance: cfg_slow_dist = data;
      CfgSlowSpeed:    cfg_slow_spd = data[6:0];
      CfgMaxSpeed:     cfg_max_spd = data[6:0];
      CfgGainTenths:   cfg_gain = data;
      CfgPulseOffset:  cfg_offset = data;
      default: ;
    endcase
  endfunction

  // one sample through the averager and speed law
  function automatic res_t servo_predict(logic [10:0] pw, logic [8:0] tgt);
    res_t        r;
    int unsigned contrib;
    int unsigned avg;
    int unsigned mag;
    int unsigned spd;
    int          d;
    int          err;
    int          sspd;
    r = '0;
    contrib = (pw > cfg_offset) ? pw - cfg_offset : 0;
    acc_sum = 16'(acc_sum + contrib);
    win_cnt = 4'(win_cnt + 1);
    if (win_cnt >= AvgCount) begin
      avg = acc_sum / AvgCount;
      pos_deg = 10'((avg * PosScale) >> 16);
      acc_sum = '0;
      win_cnt = '0;
      r.upd = 1'b1;
    end
    // wrapped error in -180..179
    d = int'(tgt) - int'(pos_deg) + 180;
    d = d % 360;
    if (d < 0) d += 360;
    err = d - 180;
    mag = (err < 0) ? -err : err;
    if (mag < cfg_stop) begin
      spd = 0;
    end else if (mag < cfg_slow_dist) begin
      spd = cfg_slow_spd;
    end else begin
      spd = mag * cfg_gain / 10;
      if (spd < cfg_slow_spd) spd = cfg_slow_spd;
      if (spd > cfg_max_spd) spd = cfg_max_spd;
    end
    if (spd > 90) spd = 90;
    sspd = (err < 0) ? int'(spd) : -int'(spd);
    r.servo = 8'(90 + sspd);
    r.sspeed = 8'(sspd);
    r.pos = pos_deg;
    r.at_target = (spd == 0);
    return r;
  endfunction

  // directed plan builders
  function automatic void plan_item(logic [10:0] pw, logic [8:0] tgt);
    row_t row;
    row = '{kind: RowItem, idx: '0, data: '0, pw: pw, tgt: tgt, typed: 1'b0, want: '0};
    plan_q.push_back(row);
  endfunction

  function automatic void plan_typed(logic [10:0] pw, logic [8:0] tgt, logic [7:0] servo,
                                     logic [7:0] sspeed, logic at_target);
    row_t row;
    row = '{kind: RowItem, idx: '0, data: '0, pw: pw, tgt: tgt, typed: 1'b1, want: '0};
    row.want.servo = servo;
    row.want.sspeed = sspeed;
    row.want.at_target = at_target;
    plan_q.push_back(row);
  endfunction

  function automatic void plan_reg(logic [2:0] idx, logic [7:0] data);
    row_t row;
    row = '{kind: RowReg, idx: idx, data: data, pw: '0, tgt: '0, typed: 1'b0, want: '0};
    plan_q.push_back(row);
  endfunction

  // sender gap: mostly none, some short, few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // offer one request and log its command once accepted
  task automatic send_item(logic [10:0] pw, logic [8:0] tgt, bit typed, res_t typed_res);
    int   gap;
    res_t pred;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {4'b0, tgt, pw};
    do @(posedge clk_i); while (!s_axis_tready);
    pred = servo_predict(pw, tgt);
    expected_cmds.push_back(typed ? typed_res : pred);
  endtask

  // drain all pending commands, then let the pipeline empty
  task automatic settle();
    while (expected_cmds.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [7:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    servo_model_reg(idx, data);
  endtask

  // register value for one phase: defaults, zeros, all ones, range tops or random
  function automatic logic [7:0] pick_reg(int mode, int idx);
    logic [7:0] dflt[6];
    logic [7:0] top[6];
    dflt = '{8'd3, 8'd8, 8'd30, 8'd90, 8'd27, 8'd30};
    top = '{8'd180, 8'd180, 8'd90, 8'd90, 8'd255, 8'd255};
    case (mode)
      0: return dflt[idx];
      1: return 8'd0;
      2: return 8'hFF;
      3: return top[idx];
      default: begin
        if ($urandom_range(0, 7) == 0) return 8'($urandom);
        return 8'($urandom_range(0, top[idx]));
      end
    endcase
  endfunction

  task automatic report(string field, int want, int got);
    mismatch_cnt++;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
  endtask

  // result checker and receiver back-pressure
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_cmd = res_t'(m_axis_tdata[27:0]);
      results_seen++;
      if (expected_cmds.size() == 0) begin
        report("unrequested result", 0, m_axis_tdata);
      end else begin
        want_cmd = expected_cmds.pop_front();
        if (got_cmd.servo !== want_cmd.servo)
          report("servo_command", want_cmd.servo, got_cmd.servo);
        if (got_cmd.sspeed !== want_cmd.sspeed)
          report("signed_speed", want_cmd.sspeed, got_cmd.sspeed);
        if (got_cmd.pos !== want_cmd.pos)
          report("position_angle", want_cmd.pos, got_cmd.pos);
        if (got_cmd.upd !== want_cmd.upd)
          report("position_updated", want_cmd.upd, got_cmd.upd);
        if (got_cmd.at_target !== want_cmd.at_target)
          report("at_target", want_cmd.at_target, got_cmd.at_target);
      end
    end
    // one long hold-off so the pipeline backs up into the sender
    if (!hold_done && results_seen >= 400) begin
      hold_done = 1'b1;
      hold_left = 150;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (steady) begin
      m_axis_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      case ($urandom_range(0, 19))
        0, 1, 2: begin
          stall_left = $urandom_range(0, 2);
          m_axis_tready <= 1'b0;
        end
        3: begin
          stall_left = $urandom_range(10, 30);
          m_axis_tready <= 1'b0;
        end
        default: m_axis_tready <= 1'b1;
      endcase
    end
  end

  // stimulus
  initial begin
    int          base;
    int          t;
    int          r;
    logic [10:0] pw;
    logic [8:0]  tgt;

    servo_model_reset();

    // after reset, position zero
    plan_typed(11'd0, 9'd0, 8'd90, 8'd0, 1'b1);
    plan_typed(11'd0, 9'd180, 8'd180, 8'd90, 1'b0);
    plan_typed(11'd0, 9'd179, 8'd0, 8'hA6, 1'b0);
    // full-scale pulses close a window, target above a full turn
    plan_item(11'd2047, 9'd360);
    plan_item(11'd2047, 9'd511);
    // pulse at and just over the offset, stop, slow and proportional bands
    plan_item(11'd30, 9'd276);
    plan_item(11'd31, 9'd280);
    plan_item(11'd1024, 9'd270);
    plan_item(11'd1, 9'd300);
    plan_item(11'd1023, 9'd100);
    // zero speed outside the stop band
    plan_reg(CfgSlowSpeed, 8'd0);
    plan_item(11'd500, 9'd140);
    // slow speed above max speed
    plan_reg(CfgMaxSpeed, 8'd10);
    plan_reg(CfgSlowSpeed, 8'd60);
    plan_item(11'd500, 9'd130);
    plan_item(11'd500, 9'd0);
    // speeds above ninety get limited
    plan_reg(CfgSlowSpeed, 8'hFF);
    plan_reg(CfgMaxSpeed, 8'hFF);
    plan_item(11'd500, 9'd140);
    // spare indexes, then band and gain extremes
    plan_reg(CfgSpare6, 8'd0);
    plan_reg(CfgSpare7, 8'hFF);
    plan_reg(CfgStopDistance, 8'd0);
    plan_reg(CfgSlowDistance, 8'd0);
    plan_reg(CfgGainTenths, 8'd0);
    plan_reg(CfgPulseOffset, 8'hFF);
    plan_item(11'd255, 9'd135);
    plan_item(11'd256, 9'd50);
    plan_reg(CfgGainTenths, 8'hFF);
    plan_reg(CfgSlowSpeed, 8'd0);
    plan_reg(CfgMaxSpeed, 8'd90);
    plan_item(11'd2047, 9'd0);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed plan
    foreach (plan_q[i]) begin
      if (plan_q[i].kind == RowReg) begin
        if (!cfg_open) begin
          s_axis_tvalid <= 1'b0;
          settle();
          cfg_open = 1'b1;
        end
        write_reg(plan_q[i].idx, plan_q[i].data);
      end else begin
        if (cfg_open) begin
          cfg_valid_i <= 1'b0;
          cfg_open = 1'b0;
        end
        send_item(plan_q[i].pw, plan_q[i].tgt, plan_q[i].typed, plan_q[i].want);
      end
    end
    cfg_valid_i <= 1'b0;

    // random phases, each with fresh register settings
    for (int ph = 0; ph < NumPhases; ph++) begin
      s_axis_tvalid <= 1'b0;
      settle();
      for (int k = 0; k < 6; k++) write_reg(3'(k), pick_reg(ph, k));
      if ($urandom_range(0, 1) == 1)
        write_reg($urandom_range(0, 1) ? CfgSpare6 : CfgSpare7, 8'($urandom));
      cfg_valid_i <= 1'b0;
      steady = (ph == 3);
      base = $urandom_range(30, 1100);
      for (int n = 0; n < PhaseItems; n++) begin
        // steady feedback around a drifting base, with some wild samples
        if ($urandom_range(0, 99) < 85) begin
          if ($urandom_range(0, 29) == 0) base = $urandom_range(30, 1100);
          t = base + $urandom_range(0, 40) - 20;
          pw = 11'((t < 0) ? 0 : t);
        end else begin
          pw = 11'($urandom_range(0, 2047));
        end
        // targets near the position, across the turn, or above a full turn
        r = $urandom_range(0, 99);
        if (r < 40) begin
          t = int'(pos_deg) + $urandom_range(0, 24) - 12;
          t = ((t % 360) + 360) % 360;
          tgt = 9'(t);
        end else if (r < 85) begin
          tgt = 9'($urandom_range(0, 360));
        end else begin
          tgt = 9'($urandom_range(0, 511));
        end
        send_item(pw, tgt, 1'b0, '0);
      end
      steady = 1'b0;
    end
    s_axis_tvalid <= 1'b0;

    settle();
    repeat (20) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
